// File: rtl/core/weht_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// weht_pkg
// shared types and constants of the weak edge hysteresis tracker
// ---------------------------------------------------------------------------
package weht_pkg;

	localparam int PIX_W   = 8;
	localparam int COORD_W = 12;
	localparam int GEOM_W  = 13;
	localparam int HEIGHT_MAX = 4096;

	// configuration register indexes
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_WEAK_LEVEL   = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_STRONG_LEVEL = 2'd3;

	localparam int RESET_WIDTH  = 640;
	localparam int RESET_HEIGHT = 480;
	localparam logic [PIX_W-1:0] RESET_WEAK   = 8'd127;
	localparam logic [PIX_W-1:0] RESET_STRONG = 8'd255;

	// result kinds of one pixel, in emission order
	localparam int NUM_KINDS = 4;
	localparam logic [1:0] KIND_CENTER = 2'd0;
	localparam logic [1:0] KIND_RIGHT  = 2'd1;
	localparam logic [1:0] KIND_BOTTOM = 2'd2;
	localparam logic [1:0] KIND_CORNER = 2'd3;

	// queue between front and back
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W = 2;
	localparam int QCNT_W = 3;

	// controls from the register block to the front
	typedef struct packed {
		logic               restart;
		logic [COORD_W-1:0] h_last;
		logic [PIX_W-1:0]   weak_level;
		logic [PIX_W-1:0]   strong_level;
	} weht_ctrl_t;

	// one classified pixel: which results it makes and their values
	typedef struct packed {
		logic [NUM_KINDS-1:0]            kinds;
		logic [NUM_KINDS-1:0][PIX_W-1:0] vals;
		logic [COORD_W-1:0]              row;
		logic [COORD_W-1:0]              col;
	} weht_entry_t;

endpackage
`default_nettype wire

// File: rtl/core/weht_pixel_if.sv
`default_nettype none
// ---------------------------------------------------------------------------
// weht_pixel_if
// pixel request channel: valid, ready and one greyscale pixel
// ---------------------------------------------------------------------------
interface weht_pixel_if import weht_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [PIX_W-1:0] pixel;

	modport source(output valid, output pixel, input ready);
	modport sink(input valid, input pixel, output ready);
endinterface
`default_nettype wire

// File: rtl/core/weht_result_if.sv
`default_nettype none
// ---------------------------------------------------------------------------
// weht_result_if
// result request channel: tracked pixel value with its position
// ---------------------------------------------------------------------------
interface weht_result_if import weht_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [PIX_W-1:0]   value;
	logic [COORD_W-1:0] row;
	logic [COORD_W-1:0] col;
	logic               last;
	logic               frame_done;

	modport source(output valid, output value, output row, output col,
		output last, output frame_done, input ready);
	modport sink(input valid, input value, input row, input col,
		input last, input frame_done, output ready);
endinterface
`default_nettype wire

// File: rtl/core/weht_front.sv
`default_nettype none
// ---------------------------------------------------------------------------
// weht_front
// accepts pixels, keeps line store and window, classifies each pixel
// ---------------------------------------------------------------------------
module weht_front import weht_pkg::*; #(
	parameter int MAX_WIDTH = 4096
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire weht_ctrl_t                   ctrl,
	input  wire logic [$clog2(MAX_WIDTH)-1:0] w_last,
	weht_pixel_if.sink                        pixels,
	output logic                              push,
	output weht_entry_t                       push_entry,
	input  wire logic                         push_ready
);
	localparam int CW = $clog2(MAX_WIDTH);

	logic [CW-1:0]      c_q;
	logic [COORD_W-1:0] r_q;

	// line store: [15:8] row r-2, [7:0] row r-1
	logic [2*PIX_W-1:0] lines [MAX_WIDTH];
	logic [2*PIX_W-1:0] rd_s1;

	logic               valid_s1;
	logic [PIX_W-1:0]   px_s1;
	logic [CW-1:0]      addr_s1;
	logic [COORD_W-1:0] row_s1;
	logic [COORD_W-1:0] col_s1;
	logic               r_ge1_s1, r_ge2_s1, c_ge1_s1, c_ge2_s1, c_last_s1, r_last_s1;

	// window columns c-2 and c-1 of the previous step, rows top to bottom
	logic [PIX_W-1:0] col1_q [3];
	logic [PIX_W-1:0] col2_q [3];

	logic accept, advance;
	logic [NUM_KINDS-1:0] kinds;
	logic [PIX_W-1:0] up_px, mid_px, center, tracked, v0;
	logic any_strong;

	assign up_px  = rd_s1[2*PIX_W-1:PIX_W];
	assign mid_px = rd_s1[PIX_W-1:0];
	assign center = col2_q[1];

	assign kinds[KIND_CENTER] = r_ge1_s1 & c_ge1_s1;
	assign kinds[KIND_RIGHT]  = r_ge1_s1 & c_last_s1;
	assign kinds[KIND_BOTTOM] = r_last_s1 & c_ge1_s1;
	assign kinds[KIND_CORNER] = r_last_s1 & c_last_s1;

	assign advance = valid_s1 && ((kinds == '0) || push_ready);
	assign push    = valid_s1 && (kinds != '0) && push_ready;
	assign accept  = pixels.valid && pixels.ready;
	assign pixels.ready = !valid_s1 || advance;

	// eight neighbours of the center after the shift
	always_comb begin
		any_strong = (col1_q[0] == ctrl.strong_level) || (col1_q[1] == ctrl.strong_level)
			|| (col1_q[2] == ctrl.strong_level) || (col2_q[0] == ctrl.strong_level)
			|| (col2_q[2] == ctrl.strong_level) || (up_px == ctrl.strong_level)
			|| (mid_px == ctrl.strong_level) || (px_s1 == ctrl.strong_level);
		if (center != ctrl.weak_level) begin
			tracked = center;
		end else if (any_strong) begin
			tracked = ctrl.strong_level;
		end else begin
			tracked = '0;
		end
		v0 = (r_ge2_s1 && c_ge2_s1) ? tracked : center;
	end

	always_comb begin
		push_entry.kinds = kinds;
		push_entry.vals[KIND_CENTER] = v0;
		push_entry.vals[KIND_RIGHT]  = mid_px;
		push_entry.vals[KIND_BOTTOM] = col2_q[2];
		push_entry.vals[KIND_CORNER] = px_s1;
		push_entry.row = row_s1;
		push_entry.col = col_s1;
	end

	// position counters and stage valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			c_q <= '0;
			r_q <= '0;
			valid_s1 <= 1'b0;
		end else begin
			if (ctrl.restart) begin
				c_q <= '0;
				r_q <= '0;
			end else if (accept) begin
				if (c_q == w_last) begin
					c_q <= '0;
					r_q <= (r_q == ctrl.h_last) ? '0 : r_q + 1'b1;
				end else begin
					c_q <= c_q + 1'b1;
				end
			end
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	// stage 1 payload
	always_ff @(posedge clk) begin
		if (accept) begin
			px_s1     <= pixels.pixel;
			addr_s1   <= c_q;
			row_s1    <= r_q;
			col_s1    <= COORD_W'(32'(c_q));
			r_ge1_s1  <= (r_q != '0);
			r_ge2_s1  <= (r_q > COORD_W'(1));
			c_ge1_s1  <= (c_q != '0);
			c_ge2_s1  <= (c_q > CW'(1));
			c_last_s1 <= (c_q == w_last);
			r_last_s1 <= (r_q == ctrl.h_last);
		end
	end

	// line store: read on accept, write back once the pixel leaves stage 1
	always_ff @(posedge clk) begin
		if (accept) begin
			rd_s1 <= lines[c_q];
		end
		if (advance) begin
			lines[addr_s1] <= {mid_px, px_s1};
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			col1_q <= col2_q;
			col2_q[0] <= up_px;
			col2_q[1] <= mid_px;
			col2_q[2] <= px_s1;
		end
	end
endmodule
`default_nettype wire

// File: rtl/core/weht_queue.sv
`default_nettype none
// ---------------------------------------------------------------------------
// weht_queue
// short queue of classified pixels between front and back
// ---------------------------------------------------------------------------
module weht_queue import weht_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        push,
	input  wire weht_entry_t push_entry,
	output logic             push_ready,
	output logic             head_valid,
	output weht_entry_t      head_entry,
	input  wire logic        pop
);
	weht_entry_t        slots [QUEUE_DEPTH];
	logic [QPTR_W-1:0]  wr_ptr_q, rd_ptr_q;
	logic [QCNT_W-1:0]  count_q;

	assign push_ready = (count_q != QCNT_W'(QUEUE_DEPTH));
	assign head_valid = (count_q != '0);
	assign head_entry = slots[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slots[wr_ptr_q] <= push_entry;
		end
	end
endmodule
`default_nettype wire

// File: rtl/core/weht_back.sv
`default_nettype none
// ---------------------------------------------------------------------------
// weht_back
// expands each classified pixel into its results, one per cycle while the receiver is ready
// ---------------------------------------------------------------------------
module weht_back import weht_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        head_valid,
	input  wire weht_entry_t head_entry,
	output logic             pop,
	weht_result_if.source    results
);
	logic [NUM_KINDS-1:0] sent_q, remaining, sel;
	logic [1:0]           kind;
	logic                 is_last, load;
	logic                 out_valid_q;
	logic [PIX_W-1:0]     value_q;
	logic [COORD_W-1:0]   row_q, col_q;
	logic                 last_q, done_q;

	always_comb begin
		remaining = head_entry.kinds & ~sent_q;
		sel = remaining & (~remaining + 1'b1);
		is_last = ((remaining & ~sel) == '0);
		if (remaining[KIND_CENTER]) begin
			kind = KIND_CENTER;
		end else if (remaining[KIND_RIGHT]) begin
			kind = KIND_RIGHT;
		end else if (remaining[KIND_BOTTOM]) begin
			kind = KIND_BOTTOM;
		end else begin
			kind = KIND_CORNER;
		end
	end

	assign load = head_valid && (!out_valid_q || results.ready);
	assign pop  = load && is_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			sent_q <= '0;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
				sent_q <= is_last ? '0 : (sent_q | sel);
			end else if (results.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			value_q <= head_entry.vals[kind];
			row_q <= (kind == KIND_CENTER || kind == KIND_RIGHT)
				? head_entry.row - 1'b1 : head_entry.row;
			col_q <= (kind == KIND_CENTER || kind == KIND_BOTTOM)
				? head_entry.col - 1'b1 : head_entry.col;
			last_q <= is_last;
			done_q <= (kind == KIND_CORNER);
		end
	end

	assign results.valid      = out_valid_q;
	assign results.value      = value_q;
	assign results.row        = row_q;
	assign results.col        = col_q;
	assign results.last       = last_q;
	assign results.frame_done = done_q;
endmodule
`default_nettype wire

// File: rtl/core/weak_edge_hysteresis_tracker_top.sv
`default_nettype none
// ---------------------------------------------------------------------------
// weak_edge_hysteresis_tracker_top
// 3x3 hysteresis edge tracking over a raster pixel stream
// ---------------------------------------------------------------------------
// pixels arrive in raster order and one can be accepted every cycle while the
// queue has room. a pixel equal to the weak level, away from the frame border,
// comes out as the strong level when one of its eight neighbours is strong
// and as zero otherwise; all other pixels come out unchanged. pixel (r,c)
// releases pixel (r-1,c-1) and, at the right edge and on the last row, the
// border pixels that have become known, so one pixel request makes zero to
// four result requests (two at a row end or on the last row, four at the
// bottom-right corner). results leave the output register at one per cycle
// while the receiver is ready; a four-entry queue between the classifying
// front and the emitting back absorbs the bursts. the earliest result of a
// pixel passes the stage-1 register, a queue slot and the output register.
// the two previous rows sit in one 16-bit wide memory of MAX_WIDTH words,
// read when a pixel is taken and written back when it leaves stage 1; no
// clearing pass follows reset since no row is used before it is written.
// writing frame_width or frame_height restarts the frame at row 0, column 0.
// out-of-range geometry is clamped: width to 3..MAX_WIDTH, height to 3..4096.
// ---------------------------------------------------------------------------
module weak_edge_hysteresis_tracker_top import weht_pkg::*; #(
	parameter int MAX_WIDTH = 4096
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_wr_en,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [GEOM_W-1:0]    cfg_data,
	weht_pixel_if.sink                pixels,
	weht_result_if.source             results
);
	localparam int CW = $clog2(MAX_WIDTH);
	localparam int RESET_W_LAST = (RESET_WIDTH > MAX_WIDTH) ? MAX_WIDTH - 1 : RESET_WIDTH - 1;

	// clamped geometry, kept as last column and last row
	logic [CW-1:0]      w_last_q, w_last_d;
	logic [COORD_W-1:0] h_last_q, h_last_d;
	logic [PIX_W-1:0]   weak_q, strong_q;
	logic [31:0]        data_m1;

	weht_ctrl_t  ctrl;
	logic        push, push_ready, head_valid, pop;
	weht_entry_t push_entry, head_entry;

	assign data_m1 = 32'(cfg_data) - 32'd1;

	always_comb begin
		if (cfg_data < GEOM_W'(3)) begin
			w_last_d = CW'(2);
		end else if (32'(cfg_data) > 32'(MAX_WIDTH)) begin
			w_last_d = CW'(MAX_WIDTH - 1);
		end else begin
			w_last_d = data_m1[CW-1:0];
		end
		if (cfg_data < GEOM_W'(3)) begin
			h_last_d = COORD_W'(2);
		end else if (32'(cfg_data) > 32'(HEIGHT_MAX)) begin
			h_last_d = COORD_W'(HEIGHT_MAX - 1);
		end else begin
			h_last_d = data_m1[COORD_W-1:0];
		end
	end

	// register writes; unknown indexes fall through
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w_last_q <= CW'(RESET_W_LAST);
			h_last_q <= COORD_W'(RESET_HEIGHT - 1);
			weak_q   <= RESET_WEAK;
			strong_q <= RESET_STRONG;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				CFG_FRAME_WIDTH:  w_last_q <= w_last_d;
				CFG_FRAME_HEIGHT: h_last_q <= h_last_d;
				CFG_WEAK_LEVEL:   weak_q   <= cfg_data[PIX_W-1:0];
				CFG_STRONG_LEVEL: strong_q <= cfg_data[PIX_W-1:0];
				default: ;
			endcase
		end
	end

	// a geometry write sends the position counters back to the frame start
	always_comb begin
		ctrl.restart = cfg_wr_en &&
			(cfg_index == CFG_FRAME_WIDTH || cfg_index == CFG_FRAME_HEIGHT);
		ctrl.h_last       = h_last_q;
		ctrl.weak_level   = weak_q;
		ctrl.strong_level = strong_q;
	end

	// front: window, line store and classification
	weht_front #(
		.MAX_WIDTH(MAX_WIDTH)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctrl       (ctrl),
		.w_last     (w_last_q),
		.pixels     (pixels),
		.push       (push),
		.push_entry (push_entry),
		.push_ready (push_ready)
	);

	// decouples the pixel side from the result side
	weht_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.push_ready (push_ready),
		.head_valid (head_valid),
		.head_entry (head_entry),
		.pop        (pop)
	);

	// back: one result per cycle into the output register while the receiver is ready
	weht_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head_entry (head_entry),
		.pop        (pop),
		.results    (results)
	);
endmodule
`default_nettype wire

// File: sim/weht_tracking_checker.sv
`default_nettype none
// ---------------------------------------------------------------------------
// weht_tracking_checker
// watches the pixel and result channels and the register port of the edge
// tracker, models the line stores and 3x3 window, and compares every result
// against the oldest predicted tracked pixel
// ---------------------------------------------------------------------------
module weht_tracking_checker import weht_pkg::*; #(
	parameter int MAX_WIDTH = 4096
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_wr_en,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [GEOM_W-1:0]    cfg_data,
	weht_pixel_if                     pixels,
	weht_result_if                    results,
	output int                        fail_count,
	output int                        pending
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [PIX_W-1:0]   value;
		logic [COORD_W-1:0] row;
		logic [COORD_W-1:0] col;
		logic               last;
		logic               frame_done;
	} tracked_px_t;

	logic [GEOM_W-1:0] frame_w;
	logic [GEOM_W-1:0] frame_h;
	logic [PIX_W-1:0]  weak_lvl;
	logic [PIX_W-1:0]  strong_lvl;

	logic [PIX_W-1:0] row_two_up [MAX_WIDTH];
	logic [PIX_W-1:0] row_one_up [MAX_WIDTH];
	logic [PIX_W-1:0] win [3][3];
	int unsigned      next_row;
	int unsigned      next_col;

	tracked_px_t tracked_due [$];

	function automatic int unsigned clamp_dim(input int unsigned v, input int unsigned hi);
		if (v < 3) return 3;
		if (v > hi) return hi;
		return v;
	endfunction

	// weak center turns strong next to a strong pixel, zero otherwise
	function automatic logic [PIX_W-1:0] hysteresis_center();
		if (win[1][1] != weak_lvl) return win[1][1];
		for (int i = 0; i < 3; i++)
			for (int j = 0; j < 3; j++)
				if ((i != 1 || j != 1) && win[i][j] == strong_lvl) return strong_lvl;
		return '0;
	endfunction

	function automatic tracked_px_t tracked(input logic [PIX_W-1:0] value,
		input int unsigned row, input int unsigned col, input logic done);
		tracked_px_t t;
		t.value      = value;
		t.row        = COORD_W'(row);
		t.col        = COORD_W'(col);
		t.last       = 1'b0;
		t.frame_done = done;
		return t;
	endfunction

	task automatic track_pixel(input logic [PIX_W-1:0] px);
		int unsigned w, h, r, c, n;
		tracked_px_t burst [4];
		w = clamp_dim(frame_w, MAX_WIDTH);
		h = clamp_dim(frame_h, HEIGHT_MAX);
		if (next_col >= w) begin
			next_col = 0;
			next_row++;
		end
		if (next_row >= h) next_row = 0;
		r = next_row;
		c = next_col;

		for (int i = 0; i < 3; i++) begin
			win[i][0] = win[i][1];
			win[i][1] = win[i][2];
		end
		win[0][2] = row_two_up[c];
		win[1][2] = row_one_up[c];
		win[2][2] = px;
		row_two_up[c] = row_one_up[c];
		row_one_up[c] = px;

		n = 0;
		if (r >= 1 && c >= 1) begin
			burst[n] = tracked((r >= 2 && c >= 2) ? hysteresis_center() : win[1][1],
				r - 1, c - 1, 1'b0);
			n++;
		end
		if (r >= 1 && c == w - 1) begin
			burst[n] = tracked(win[1][2], r - 1, w - 1, 1'b0);
			n++;
		end
		if (r == h - 1 && c >= 1) begin
			burst[n] = tracked(win[2][1], h - 1, c - 1, 1'b0);
			n++;
		end
		if (r == h - 1 && c == w - 1) begin
			burst[n] = tracked(px, h - 1, w - 1, 1'b1);
			n++;
		end
		if (n > 0) burst[n-1].last = 1'b1;
		for (int k = 0; k < n; k++) tracked_due.push_back(burst[k]);

		next_col = c + 1;
		if (next_col >= w) begin
			next_col = 0;
			next_row = r + 1;
			if (next_row >= h) next_row = 0;
		end
	endtask

	function automatic void check_field(input string name, input logic [31:0] want,
		input logic [31:0] got);
		if (got !== want) begin
			$error("%s mismatch: expected %0d, got %0d", name, want, got);
			fail_count++;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		tracked_px_t want;
		if (!arst_n) begin
			frame_w    = GEOM_W'(RESET_WIDTH);
			frame_h    = GEOM_W'(RESET_HEIGHT);
			weak_lvl   = RESET_WEAK;
			strong_lvl = RESET_STRONG;
			for (int i = 0; i < MAX_WIDTH; i++) begin
				row_two_up[i] = '0;
				row_one_up[i] = '0;
			end
			for (int i = 0; i < 3; i++)
				for (int j = 0; j < 3; j++) win[i][j] = '0;
			next_row = 0;
			next_col = 0;
			tracked_due.delete();
			fail_count = 0;
		end else begin
			// results of this edge belong to pixels taken earlier
			if (results.valid && results.ready) begin
				if (tracked_due.size() == 0) begin
					$error("result with no pending pixel: row %0d col %0d value %0d",
						results.row, results.col, results.value);
					fail_count++;
				end else begin
					want = tracked_due.pop_front();
					check_field("value", want.value, results.value);
					check_field("row", want.row, results.row);
					check_field("col", want.col, results.col);
					check_field("last", want.last, results.last);
					check_field("frame_done", want.frame_done, results.frame_done);
				end
			end
			if (cfg_wr_en) begin
				case (cfg_index)
					CFG_FRAME_WIDTH: begin
						frame_w  = cfg_data;
						next_row = 0;
						next_col = 0;
					end
					CFG_FRAME_HEIGHT: begin
						frame_h  = cfg_data;
						next_row = 0;
						next_col = 0;
					end
					CFG_WEAK_LEVEL:   weak_lvl   = cfg_data[PIX_W-1:0];
					CFG_STRONG_LEVEL: strong_lvl = cfg_data[PIX_W-1:0];
					default: ;
				endcase
			end
			if (pixels.valid && pixels.ready) track_pixel(pixels.pixel);
		end
		pending = tracked_due.size();
	end

endmodule
`default_nettype wire

// File: sim/weak_edge_hysteresis_tracker_top_tb.sv
`default_nettype none
// ---------------------------------------------------------------------------
// weak_edge_hysteresis_tracker_top_tb
// regression of the 3x3 weak edge hysteresis tracker
// ---------------------------------------------------------------------------
// streams raster pixels through the tracker under bursty requests and a
// stalling receiver. a directed start covers strong-linked and isolated weak
// centers and weak border pixels; random phases then vary geometry (clamped
// sizes included) and levels (extremes and weak equal to strong) between
// partial and whole frames. a side checker predicts every result and counts
// failures; this module only drives and gives the verdict.
// ---------------------------------------------------------------------------
module weak_edge_hysteresis_tracker_top_tb;
	import weht_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int MAX_WIDTH      = 4096;
	localparam int RANDOM_ITEMS   = 400;
	localparam int SETTLE_CYCLES  = 12;   // a row-0 pixel may still be in flight
	localparam int WATCHDOG_LIMIT = 2000;

	// frame with a weak center touching a strong pixel; weak left border stays
	localparam logic [PIX_W-1:0] FRAME_LINKED [9] = '{
		8'd0,   8'd255, 8'd127,
		8'd127, 8'd127, 8'd0,
		8'd1,   8'd2,   8'd127
	};
	// weak center with near-strong neighbours only, so it drops to zero
	localparam logic [PIX_W-1:0] FRAME_ISOLATED [9] = '{
		8'd128, 8'd126, 8'd127,
		8'd254, 8'd127, 8'd1,
		8'd127, 8'd0,   8'd128
	};

	typedef enum int {SINK_OPEN, SINK_COIN, SINK_MOSTLY, SINK_BLOCKS} stall_style_e;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	logic                 cfg_wr_en = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [GEOM_W-1:0]    cfg_data  = '0;

	logic             pix_valid  = 1'b0;
	logic [PIX_W-1:0] pix_data   = '0;
	logic             sink_ready = 1'b0;

	int fail_count;
	int pending;

	weht_pixel_if  pix_ch ();
	weht_result_if res_ch ();

	assign pix_ch.valid = pix_valid;
	assign pix_ch.pixel = pix_data;
	assign res_ch.ready = sink_ready;

	always #5 clk = ~clk;

	weak_edge_hysteresis_tracker_top #(
		.MAX_WIDTH(MAX_WIDTH)
	) DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.pixels   (pix_ch),
		.results  (res_ch)
	);

	weht_tracking_checker #(
		.MAX_WIDTH(MAX_WIDTH)
	) u_checker (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.pixels    (pix_ch),
		.results   (res_ch),
		.fail_count(fail_count),
		.pending   (pending)
	);

	// levels currently programmed, so stimulus can hit them on purpose
	logic [PIX_W-1:0] cur_weak   = RESET_WEAK;
	logic [PIX_W-1:0] cur_strong = RESET_STRONG;

	int burst_left   = 0;
	int random_items = 0;

	// receiver: draws a new stall style whenever the current one runs out, the
	// open style giving stretches with no back-pressure at all
	stall_style_e stall_style = SINK_OPEN;
	int           style_left  = 0;
	int           block_left  = 0;

	always @(negedge clk) begin
		if (style_left == 0) begin
			stall_style = stall_style_e'($urandom_range(0, 3));
			style_left  = $urandom_range(20, 120);
		end
		style_left--;
		case (stall_style)
			SINK_OPEN:   sink_ready <= 1'b1;
			SINK_COIN:   sink_ready <= ($urandom_range(0, 1) == 1);
			SINK_MOSTLY: sink_ready <= ($urandom_range(0, 4) != 0);
			default: begin
				// long blocks of back-pressure
				if (block_left > 0) begin
					block_left--;
					sink_ready <= 1'b0;
				end else begin
					sink_ready <= 1'b1;
					if ($urandom_range(0, 7) == 0) block_left = $urandom_range(2, 12);
				end
			end
		endcase
	end

	// watchdog: too long without any accepted request or register write
	int idle_cycles = 0;

	always @(posedge clk) begin
		if (!arst_n || cfg_wr_en || (pix_valid && pix_ch.ready) ||
				(res_ch.valid && sink_ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("weak_edge_hysteresis_tracker_top regression: fail");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// one pixel request; the sender runs in bursts with random gaps between
	task automatic send_pixel(input logic [PIX_W-1:0] px);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				pix_valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		burst_left--;
		pix_valid <= 1'b1;
		pix_data  <= px;
		do @(posedge clk); while (!pix_ch.ready);
		@(negedge clk);
	endtask

	// stop sending and wait for every predicted result, then let the design settle
	task automatic settle();
		pix_valid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [GEOM_W-1:0] data);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(negedge clk);
	endtask

	// writes the registers selected by sel (bit position = register index);
	// level writes carry junk in the unused upper data bits
	task automatic configure(input bit [3:0] sel, input logic [GEOM_W-1:0] w,
		input logic [GEOM_W-1:0] h, input logic [PIX_W-1:0] wk, input logic [PIX_W-1:0] st);
		logic [GEOM_W-1:0] junk;
		junk = GEOM_W'($urandom_range(0, 31)) << PIX_W;
		if (sel[CFG_FRAME_WIDTH]) write_reg(CFG_FRAME_WIDTH, w);
		if (sel[CFG_FRAME_HEIGHT]) write_reg(CFG_FRAME_HEIGHT, h);
		if (sel[CFG_WEAK_LEVEL]) begin
			write_reg(CFG_WEAK_LEVEL, junk | GEOM_W'(wk));
			cur_weak = wk;
		end
		if (sel[CFG_STRONG_LEVEL]) begin
			write_reg(CFG_STRONG_LEVEL, junk | GEOM_W'(st));
			cur_strong = st;
		end
		if (sel != '0) cfg_wr_en <= 1'b0;
	endtask

	// mostly weak and strong pixels so the tracking decisions get exercised
	function automatic logic [PIX_W-1:0] pick_pixel();
		int roll;
		roll = $urandom_range(0, 19);
		if (roll < 7) return cur_weak;
		if (roll < 12) return cur_strong;
		return PIX_W'($urandom_range(0, 255));
	endfunction

	// frame sizes: mostly small, sometimes below the clamp, often the minimum
	function automatic logic [GEOM_W-1:0] pick_dim(input int unsigned hi);
		int roll;
		roll = $urandom_range(0, 9);
		if (roll == 0) return GEOM_W'($urandom_range(0, 2));
		if (roll < 3) return GEOM_W'(3);
		return GEOM_W'($urandom_range(4, hi));
	endfunction

	function automatic logic [PIX_W-1:0] pick_level();
		case ($urandom_range(0, 3))
			0:       return '0;
			1:       return '1;
			default: return PIX_W'($urandom_range(0, 255));
		endcase
	endfunction

	initial begin
		bit [3:0]          sel;
		logic [PIX_W-1:0]  wk, st;
		int                n;

		repeat (5) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset geometry is 640 wide: a few row-0 pixels make no results
		repeat (6) send_pixel(pick_pixel());
		settle();

		// directed: 3x3 frames at the reset levels, restart via geometry write
		configure(4'b0011, GEOM_W'(3), GEOM_W'(3), RESET_WEAK, RESET_STRONG);
		foreach (FRAME_LINKED[i]) send_pixel(FRAME_LINKED[i]);
		foreach (FRAME_ISOLATED[i]) send_pixel(FRAME_ISOLATED[i]);
		settle();

		// random phases; frames often run on across phases that only touch
		// the levels, so level changes land mid-frame too
		while (random_items < RANDOM_ITEMS) begin
			sel = '0;
			sel[CFG_FRAME_WIDTH]  = ($urandom_range(0, 4) < 2);
			sel[CFG_FRAME_HEIGHT] = ($urandom_range(0, 4) < 2);
			sel[CFG_WEAK_LEVEL]   = ($urandom_range(0, 4) < 2);
			sel[CFG_STRONG_LEVEL] = ($urandom_range(0, 4) < 2);
			wk = pick_level();
			st = ($urandom_range(0, 4) == 0) ? wk : pick_level();
			configure(sel, pick_dim(12), pick_dim(8), wk, st);
			n = $urandom_range(10, 70);
			repeat (n) begin
				send_pixel(pick_pixel());
				random_items++;
			end
			settle();
		end

		// widest rows: width above the limit clamps to MAX_WIDTH; a short
		// stretch of row 0 runs at that width before the next restart
		configure(4'b1111, '1, GEOM_W'(3), pick_level(), pick_level());
		repeat (24) send_pixel(pick_pixel());
		settle();

		// tallest frame: height above the limit, narrowest rows
		configure(4'b0011, GEOM_W'(3), '1, cur_weak, cur_strong);
		repeat (45) send_pixel(pick_pixel());
		settle();

		if (fail_count == 0) begin
			$display("weak_edge_hysteresis_tracker_top regression: pass");
		end else begin
			$display("weak_edge_hysteresis_tracker_top regression: fail");
		end
		$finish;
	end

endmodule
`default_nettype wire

// File: sim.f
rtl/core/weht_pkg.sv
rtl/core/weht_pixel_if.sv
rtl/core/weht_result_if.sv
rtl/core/weht_front.sv
rtl/core/weht_queue.sv
rtl/core/weht_back.sv
rtl/core/weak_edge_hysteresis_tracker_top.sv
sim/weht_tracking_checker.sv
sim/weak_edge_hysteresis_tracker_top_tb.sv
